// ----- hw/rtl/tlcp_pkg.sv -----
// ----------------------------------------------------------------------------
// Tiled label collision placer package
// Shared widths, status codes, sequencer states and control structures.
// ----------------------------------------------------------------------------
package tlcp_pkg;

    localparam int GRID_COLUMNS_MAX_DEF = 16;
    localparam int GRID_ROWS_MAX_DEF    = 16;
    localparam int SLOTS_PER_TILE_DEF   = 8;
    localparam int TILE_PIXELS_LOG2_DEF = 7;

    localparam int CW  = 20;        // rotated corner, Q.4
    localparam int AXW = CW + 1;    // edge axis
    localparam int PRW = 2 * AXW;   // one product of a dot product
    localparam int DW  = PRW + 1;   // dot product
    localparam int PW  = DW + 1;    // origin plus squared length
    localparam int BW  = CW + 2;    // tile coordinate arithmetic

    localparam logic [1:0] CFG_TILES_ACROSS = 2'd0;
    localparam logic [1:0] CFG_TILES_DOWN   = 2'd1;
    localparam logic [1:0] CFG_PLACE_ALL    = 2'd2;

    localparam logic [4:0] DOT_NEW_FIRST  = 5'd0;
    localparam logic [4:0] DOT_NEW_LAST   = 5'd3;
    localparam logic [4:0] DOT_PAIR_FIRST = 5'd4;
    localparam logic [4:0] DOT_PAIR_LAST  = 5'd23;

    localparam logic [1:0] DOT_GRP_BOX    = 2'd0;
    localparam logic [1:0] DOT_GRP_S_ON_N = 2'd1;
    localparam logic [1:0] DOT_GRP_N_ON_S = 2'd2;

    typedef enum logic [2:0] {
        STATUS_PLACED   = 3'd0,
        STATUS_OFF      = 3'd1,
        STATUS_OVERLAP  = 3'd2,
        STATUS_FULL     = 3'd3,
        STATUS_CLEARED  = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_CMUL, S_CADD, S_BOUNDS, S_BCHK, S_NISSUE, S_NDRAIN,
        S_FILL_RD, S_FILL_CHK, S_SLOT_RD, S_SLOT_CHK, S_PISSUE, S_PDRAIN,
        S_PEVAL, S_ST_RD, S_ST_WR, S_FINISH
    } state_t;

    typedef struct packed {
        logic       load;
        logic       corner_mul;
        logic       corner_add;
        logic [1:0] corner_k;
        logic       bounds;
        logic       dot_go;
        logic [4:0] dot_op;
        logic       scan_first;
        logic       tile_step;
        logic       fill_rd;
        logic       slot_first;
        logic       slot_step;
        logic       slot_rd;
        logic       store_wr;
        logic       clear;
    } cmd_t;

    typedef struct packed {
        logic op_clear;
        logic off_screen;
        logic fill_zero;
        logic tile_full;
        logic slot_last;
        logic tile_last;
        logic both_upright;
        logic aa_overlap;
        logic sat_overlap;
    } stat_t;

endpackage

// ----- hw/rtl/tlcp_dp.sv -----
// ----------------------------------------------------------------------------
// Tiled label collision placer datapath
// Corner rotation, tile bounds, tile fill and slot memories, dot product unit.
// ----------------------------------------------------------------------------
module tlcp_dp import tlcp_pkg::*; #(
    parameter int GRID_COLUMNS_MAX = GRID_COLUMNS_MAX_DEF,
    parameter int GRID_ROWS_MAX    = GRID_ROWS_MAX_DEF,
    parameter int SLOTS_PER_TILE   = SLOTS_PER_TILE_DEF,
    parameter int TILE_PIXELS_LOG2 = TILE_PIXELS_LOG2_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [127:0] s_tdata,
    input  logic         s_tuser,
    input  logic [4:0]   tiles_across,
    input  logic [4:0]   tiles_down,
    input  cmd_t         cmd,
    output stat_t        stat
);

    localparam int TILES  = GRID_COLUMNS_MAX * GRID_ROWS_MAX;
    localparam int SLOTS  = TILES * SLOTS_PER_TILE;
    localparam int XW     = (GRID_COLUMNS_MAX > 1) ? $clog2(GRID_COLUMNS_MAX) : 1;
    localparam int YW     = (GRID_ROWS_MAX > 1) ? $clog2(GRID_ROWS_MAX) : 1;
    localparam int TIW    = (TILES > 1) ? $clog2(TILES) : 1;
    localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW     = $clog2(SLOTS_PER_TILE + 1);
    localparam int SIW    = (SLOTS_PER_TILE > 1) ? $clog2(SLOTS_PER_TILE) : 1;
    localparam int SH     = TILE_PIXELS_LOG2 + 4;
    localparam int SLOT_W = 8 * CW + 1;
    localparam logic signed [BW-1:0] TILE_M1 = BW'((1 << SH) - 1);

    logic                  op_reg;
    logic signed [15:0]    l_reg, r_reg, b_reg, t_reg, px_reg, py_reg, c_reg, s_reg;
    logic signed [32:0]    pdc_reg, pes_reg, pec_reg, pds_reg;
    logic signed [CW-1:0]  cx_reg [4];
    logic signed [CW-1:0]  cy_reg [4];
    logic                  upright_reg;
    logic                  off_reg;
    logic [XW-1:0]         tx0_reg, tx1_reg, tx_reg;
    logic [YW-1:0]         ty0_reg, ty1_reg, ty_reg;
    logic [SIW-1:0]        slot_i_reg;
    logic [FW-1:0]         fill_mem [TILES];
    logic [FW-1:0]         fill_q_reg;
    logic                  fill_vq_reg;
    logic [TILES-1:0]      fill_valid_reg;
    logic [SLOT_W-1:0]     slot_mem [SLOTS];
    logic [SLOT_W-1:0]     slot_q_reg;
    logic signed [PRW-1:0] prod_a_reg, prod_b_reg;
    logic [4:0]            dot_tag_reg;
    logic                  dot_vld_reg;
    logic signed [DW-1:0]  org_reg [2][2];
    logic signed [DW-1:0]  len_reg [2][2];
    logic signed [DW-1:0]  lo_reg  [2][2];
    logic signed [DW-1:0]  hi_reg  [2][2];

    logic signed [15:0]    ex_w, ey_w;
    logic signed [16:0]    d_w, e_w;
    logic signed [33:0]    sx_w, sy_w;
    logic signed [CW-1:0]  minx_w, maxx_w, miny_w, maxy_w;
    logic signed [BW-1:0]  mnx_w, mxx_w, mny_w, mxy_w, cols_w, rows_w;
    logic signed [BW-1:0]  tx0_w, tx1_w, ty0_w, ty1_w;
    logic                  off_w;
    logic [TIW-1:0]        tile_idx;
    logic [FW-1:0]         fill_n;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [SLOT_W-1:0]     new_word;
    logic signed [CW-1:0]  bx [2][4];
    logic signed [CW-1:0]  by [2][4];
    logic signed [AXW-1:0] bax [2][2];
    logic signed [AXW-1:0] bay [2][2];
    logic                  s_up;
    logic signed [AXW-1:0] dx, dy, ux, uy;
    logic signed [DW-1:0]  dot_val;
    logic [3:0]            sep;

    // Input capture and corner rotation.
    always_comb begin
        ex_w   = (cmd.corner_k == 2'd0 || cmd.corner_k == 2'd3) ? l_reg : r_reg;
        ey_w   = cmd.corner_k[1] ? t_reg : b_reg;
        d_w    = 17'(ex_w) - 17'(px_reg);
        e_w    = 17'(ey_w) - 17'(py_reg);
        sx_w   = 34'(pdc_reg) - 34'(pes_reg) + 34'sd8192;
        sy_w   = 34'(pec_reg) + 34'(pds_reg) + 34'sd8192;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_tuser;
            l_reg  <= s_tdata[15:0];
            r_reg  <= s_tdata[31:16];
            b_reg  <= s_tdata[47:32];
            t_reg  <= s_tdata[63:48];
            px_reg <= s_tdata[79:64];
            py_reg <= s_tdata[95:80];
            c_reg  <= s_tdata[111:96];
            s_reg  <= s_tdata[127:112];
        end
        if (cmd.corner_mul) begin
            pdc_reg <= 33'(d_w) * 33'(c_reg);
            pes_reg <= 33'(e_w) * 33'(s_reg);
            pec_reg <= 33'(e_w) * 33'(c_reg);
            pds_reg <= 33'(d_w) * 33'(s_reg);
        end
        if (cmd.corner_add) begin
            cx_reg[cmd.corner_k] <= CW'(sx_w >>> 14) + CW'(px_reg);
            cy_reg[cmd.corner_k] <= CW'(sy_w >>> 14) + CW'(py_reg);
            upright_reg          <= (s_reg == 16'sd0) && (c_reg == 16'sd16384);
        end
    end

    // Bounds and tile range.
    always_comb begin
        minx_w = cx_reg[0];
        maxx_w = cx_reg[0];
        miny_w = cy_reg[0];
        maxy_w = cy_reg[0];
        for (int i = 1; i < 4; i++) begin
            if (cx_reg[i] < minx_w) minx_w = cx_reg[i];
            if (cx_reg[i] > maxx_w) maxx_w = cx_reg[i];
            if (cy_reg[i] < miny_w) miny_w = cy_reg[i];
            if (cy_reg[i] > maxy_w) maxy_w = cy_reg[i];
        end
        mnx_w = BW'(minx_w) >>> SH;
        mny_w = BW'(miny_w) >>> SH;
        mxx_w = (BW'(maxx_w) + TILE_M1) >>> SH;
        mxy_w = (BW'(maxy_w) + TILE_M1) >>> SH;
        if (tiles_across == 5'd0) begin
            cols_w = BW'(1);
        end else if (int'(tiles_across) > GRID_COLUMNS_MAX) begin
            cols_w = BW'(GRID_COLUMNS_MAX);
        end else begin
            cols_w = BW'(tiles_across);
        end
        if (tiles_down == 5'd0) begin
            rows_w = BW'(1);
        end else if (int'(tiles_down) > GRID_ROWS_MAX) begin
            rows_w = BW'(GRID_ROWS_MAX);
        end else begin
            rows_w = BW'(tiles_down);
        end
        off_w = (mnx_w >= cols_w) || (mxx_w < 0) || (mny_w >= rows_w) || (mxy_w < 0);
        tx0_w = (mnx_w < 0) ? BW'(0) : mnx_w;
        ty0_w = (mny_w < 0) ? BW'(0) : mny_w;
        tx1_w = (mxx_w >= cols_w) ? cols_w - BW'(1) : mxx_w;
        ty1_w = (mxy_w >= rows_w) ? rows_w - BW'(1) : mxy_w;
    end

    always_ff @(posedge aclk) begin
        if (cmd.bounds) begin
            tx0_reg <= tx0_w[XW-1:0];
            tx1_reg <= tx1_w[XW-1:0];
            ty0_reg <= ty0_w[YW-1:0];
            ty1_reg <= ty1_w[YW-1:0];
        end
        if (cmd.scan_first) begin
            tx_reg <= tx0_reg;
            ty_reg <= ty0_reg;
        end else if (cmd.tile_step) begin
            if (ty_reg == ty1_reg) begin
                ty_reg <= ty0_reg;
                tx_reg <= tx_reg + XW'(1);
            end else begin
                ty_reg <= ty_reg + YW'(1);
            end
        end
        if (cmd.slot_first) begin
            slot_i_reg <= '0;
        end else if (cmd.slot_step) begin
            slot_i_reg <= slot_i_reg + SIW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg <= 1'b0;
        end else if (cmd.bounds) begin
            off_reg <= off_w;
        end
    end

    // Tile fill counts and slot storage.
    assign tile_idx = TIW'(tx_reg) * TIW'(GRID_ROWS_MAX) + TIW'(ty_reg);
    assign fill_n   = fill_vq_reg ? fill_q_reg : '0;
    assign rd_addr  = AW'(tile_idx) * AW'(SLOTS_PER_TILE) + AW'(slot_i_reg);
    assign wr_addr  = AW'(tile_idx) * AW'(SLOTS_PER_TILE) + AW'(fill_n);
    assign new_word = {upright_reg, cy_reg[3], cy_reg[2], cy_reg[1], cy_reg[0],
                       cx_reg[3], cx_reg[2], cx_reg[1], cx_reg[0]};

    always_ff @(posedge aclk) begin
        if (cmd.fill_rd) begin
            fill_q_reg <= fill_mem[tile_idx];
        end
        if (cmd.store_wr) begin
            fill_mem[tile_idx] <= fill_n + FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_valid_reg <= '0;
            fill_vq_reg    <= 1'b0;
        end else begin
            if (cmd.clear) begin
                fill_valid_reg <= '0;
            end else if (cmd.store_wr) begin
                fill_valid_reg[tile_idx] <= 1'b1;
            end
            if (cmd.fill_rd) begin
                fill_vq_reg <= fill_valid_reg[tile_idx];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_wr) begin
            slot_mem[wr_addr] <= new_word;
        end
        if (cmd.slot_rd) begin
            slot_q_reg <= slot_mem[rd_addr];
        end
    end

    // Box views: index 0 is the new box, index 1 the stored one.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            bx[0][k] = cx_reg[k];
            by[0][k] = cy_reg[k];
            bx[1][k] = slot_q_reg[k*CW +: CW];
            by[1][k] = slot_q_reg[(4+k)*CW +: CW];
        end
        for (int b = 0; b < 2; b++) begin
            bax[b][0] = AXW'(bx[b][1]) - AXW'(bx[b][0]);
            bay[b][0] = AXW'(by[b][1]) - AXW'(by[b][0]);
            bax[b][1] = AXW'(bx[b][3]) - AXW'(bx[b][0]);
            bay[b][1] = AXW'(by[b][3]) - AXW'(by[b][0]);
        end
        s_up = slot_q_reg[8*CW];
    end

    // Dot product unit: operand select, registered products, accumulate.
    always_comb begin
        dx = '0;
        dy = '0;
        ux = '0;
        uy = '0;
        unique case (cmd.dot_op[4:3])
            DOT_GRP_BOX: begin
                ux = bax[cmd.dot_op[2]][cmd.dot_op[0]];
                uy = bay[cmd.dot_op[2]][cmd.dot_op[0]];
                if (cmd.dot_op[1]) begin
                    dx = ux;
                    dy = uy;
                end else begin
                    dx = AXW'(bx[cmd.dot_op[2]][0]);
                    dy = AXW'(by[cmd.dot_op[2]][0]);
                end
            end
            DOT_GRP_S_ON_N: begin
                dx = AXW'(bx[1][cmd.dot_op[1:0]]);
                dy = AXW'(by[1][cmd.dot_op[1:0]]);
                ux = bax[0][cmd.dot_op[2]];
                uy = bay[0][cmd.dot_op[2]];
            end
            DOT_GRP_N_ON_S: begin
                dx = AXW'(bx[0][cmd.dot_op[1:0]]);
                dy = AXW'(by[0][cmd.dot_op[1:0]]);
                ux = bax[1][cmd.dot_op[2]];
                uy = bay[1][cmd.dot_op[2]];
            end
            default: begin
                dx = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_vld_reg <= 1'b0;
        end else begin
            dot_vld_reg <= cmd.dot_go;
        end
    end

    assign dot_val = DW'(prod_a_reg) + DW'(prod_b_reg);

    always_ff @(posedge aclk) begin
        if (cmd.dot_go) begin
            prod_a_reg  <= PRW'(dx) * PRW'(ux);
            prod_b_reg  <= PRW'(dy) * PRW'(uy);
            dot_tag_reg <= cmd.dot_op;
        end
        if (dot_vld_reg) begin
            if (dot_tag_reg[4:3] == DOT_GRP_BOX) begin
                if (dot_tag_reg[1]) begin
                    len_reg[dot_tag_reg[2]][dot_tag_reg[0]] <= dot_val;
                end else begin
                    org_reg[dot_tag_reg[2]][dot_tag_reg[0]] <= dot_val;
                end
            end else begin
                if (dot_tag_reg[1:0] == 2'd0) begin
                    lo_reg[dot_tag_reg[4]][dot_tag_reg[2]] <= dot_val;
                    hi_reg[dot_tag_reg[4]][dot_tag_reg[2]] <= dot_val;
                end else begin
                    if (dot_val < lo_reg[dot_tag_reg[4]][dot_tag_reg[2]]) begin
                        lo_reg[dot_tag_reg[4]][dot_tag_reg[2]] <= dot_val;
                    end
                    if (dot_val > hi_reg[dot_tag_reg[4]][dot_tag_reg[2]]) begin
                        hi_reg[dot_tag_reg[4]][dot_tag_reg[2]] <= dot_val;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int d = 0; d < 2; d++) begin
            for (int a = 0; a < 2; a++) begin
                sep[2*d+a] = (PW'(lo_reg[d][a]) > PW'(org_reg[d][a]) + PW'(len_reg[d][a]))
                             || (hi_reg[d][a] < org_reg[d][a]);
            end
        end
    end

    assign stat.op_clear     = op_reg;
    assign stat.off_screen   = off_reg;
    assign stat.fill_zero    = (fill_n == '0);
    assign stat.tile_full    = (fill_n >= FW'(SLOTS_PER_TILE));
    assign stat.slot_last    = ((FW+1)'(slot_i_reg) + (FW+1)'(1)) >= (FW+1)'(fill_n);
    assign stat.tile_last    = (tx_reg == tx1_reg) && (ty_reg == ty1_reg);
    assign stat.both_upright = upright_reg & s_up;
    assign stat.aa_overlap   = (bx[0][0] < bx[1][2]) && (bx[1][0] < bx[0][2]) &&
                               (by[0][0] < by[1][2]) && (by[1][0] < by[0][2]);
    assign stat.sat_overlap  = ~|sep;

endmodule

// ----- hw/rtl/tlcp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Tiled label collision placer controller
// Sequences rotation, tile scan, pair tests and storage for one request.
// ----------------------------------------------------------------------------
module tlcp_ctrl import tlcp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    place_all,
    input  logic    out_free,
    input  stat_t   stat,
    output cmd_t    cmd,
    output logic    emit,
    output status_t code
);

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic [4:0] j_reg, j_next;
    logic       full_reg, full_next;
    status_t    code_reg, code_next;
    logic       tile_done;
    logic       full_any;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            full_reg  <= 1'b0;
            code_reg  <= STATUS_PLACED;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            full_reg  <= full_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        full_next    = full_reg;
        code_next    = code_reg;
        cmd          = '0;
        cmd.corner_k = k_reg;
        cmd.dot_op   = j_reg;
        emit         = 1'b0;
        s_tready     = 1'b0;
        tile_done    = 1'b0;
        full_any     = full_reg | stat.tile_full;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    full_next  = 1'b0;
                    k_next     = '0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.op_clear) begin
                    cmd.clear  = 1'b1;
                    code_next  = STATUS_CLEARED;
                    state_next = S_FINISH;
                end else if (place_all) begin
                    code_next  = STATUS_PLACED;
                    state_next = S_FINISH;
                end else begin
                    state_next = S_CMUL;
                end
            end
            S_CMUL: begin
                cmd.corner_mul = 1'b1;
                state_next     = S_CADD;
            end
            S_CADD: begin
                cmd.corner_add = 1'b1;
                k_next         = k_reg + 2'd1;
                state_next     = (k_reg == 2'd3) ? S_BOUNDS : S_CMUL;
            end
            S_BOUNDS: begin
                cmd.bounds = 1'b1;
                state_next = S_BCHK;
            end
            S_BCHK: begin
                if (stat.off_screen) begin
                    code_next  = STATUS_OFF;
                    state_next = S_FINISH;
                end else begin
                    cmd.scan_first = 1'b1;
                    j_next         = DOT_NEW_FIRST;
                    state_next     = S_NISSUE;
                end
            end
            S_NISSUE: begin
                cmd.dot_go = 1'b1;
                j_next     = j_reg + 5'd1;
                if (j_reg == DOT_NEW_LAST) begin
                    state_next = S_NDRAIN;
                end
            end
            S_NDRAIN: begin
                state_next = S_FILL_RD;
            end
            S_FILL_RD: begin
                cmd.fill_rd = 1'b1;
                state_next  = S_FILL_CHK;
            end
            S_FILL_CHK: begin
                full_next = full_any;
                if (stat.fill_zero) begin
                    tile_done = 1'b1;
                end else begin
                    cmd.slot_first = 1'b1;
                    state_next     = S_SLOT_RD;
                end
            end
            S_SLOT_RD: begin
                cmd.slot_rd = 1'b1;
                state_next  = S_SLOT_CHK;
            end
            S_SLOT_CHK: begin
                if (stat.both_upright) begin
                    if (stat.aa_overlap) begin
                        code_next  = STATUS_OVERLAP;
                        state_next = S_FINISH;
                    end else if (stat.slot_last) begin
                        tile_done = 1'b1;
                    end else begin
                        cmd.slot_step = 1'b1;
                        state_next    = S_SLOT_RD;
                    end
                end else begin
                    j_next     = DOT_PAIR_FIRST;
                    state_next = S_PISSUE;
                end
            end
            S_PISSUE: begin
                cmd.dot_go = 1'b1;
                j_next     = j_reg + 5'd1;
                if (j_reg == DOT_PAIR_LAST) begin
                    state_next = S_PDRAIN;
                end
            end
            S_PDRAIN: begin
                state_next = S_PEVAL;
            end
            S_PEVAL: begin
                if (stat.sat_overlap) begin
                    code_next  = STATUS_OVERLAP;
                    state_next = S_FINISH;
                end else if (stat.slot_last) begin
                    tile_done = 1'b1;
                end else begin
                    cmd.slot_step = 1'b1;
                    state_next    = S_SLOT_RD;
                end
            end
            S_ST_RD: begin
                cmd.fill_rd = 1'b1;
                state_next  = S_ST_WR;
            end
            S_ST_WR: begin
                cmd.store_wr = 1'b1;
                if (stat.tile_last) begin
                    code_next  = STATUS_PLACED;
                    state_next = S_FINISH;
                end else begin
                    cmd.tile_step = 1'b1;
                    state_next    = S_ST_RD;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (tile_done) begin
            if (stat.tile_last) begin
                if (full_any) begin
                    code_next  = STATUS_FULL;
                    state_next = S_FINISH;
                end else begin
                    cmd.scan_first = 1'b1;
                    state_next     = S_ST_RD;
                end
            end else begin
                cmd.tile_step = 1'b1;
                state_next    = S_FILL_RD;
            end
        end
        code = code_reg;
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result issued while the output register is occupied");

    a_store_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_wr |-> !full_reg && !stat.tile_full)
        else $error("store into a full tile");

    a_slot_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.slot_rd |-> !stat.fill_zero)
        else $error("slot read from an empty tile");

    a_load_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_DECIDE)
        else $error("accepted beat did not start a request");

endmodule

// ----- hw/rtl/tiled_label_collision_placer.sv -----
// ----------------------------------------------------------------------------
// Tiled label collision placer
// Rotated label boxes tested against a tile grid of stored boxes.
//
//   channel   dir  fields
//   s_        in   tdata: left, right, bottom, top, pivot x/y, cos, sin; tuser: op
//   m_        out  tdata: status
//   cfg_      in   tiles_across, tiles_down, place_all
//
// A clear or place_all request goes straight to the result, an off-screen one
// after rotation and bounds. Any other placement then forms the new box's axis terms,
// reads each covered tile, tests its stored boxes (upright pairs directly, others
// on the shared dot product unit) and, if no tile is full, stores into each tile.
// Reset is synchronous; all tiles start empty. One request is handled at a time;
// a new beat is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module tiled_label_collision_placer import tlcp_pkg::*; #(
    parameter int GRID_COLUMNS_MAX = GRID_COLUMNS_MAX_DEF,
    parameter int GRID_ROWS_MAX    = GRID_ROWS_MAX_DEF,
    parameter int SLOTS_PER_TILE   = SLOTS_PER_TILE_DEF,
    parameter int TILE_PIXELS_LOG2 = TILE_PIXELS_LOG2_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_edge, right_edge, bottom_edge, top_edge, pivot_x, pivot_y,
    // cos_angle, sin_angle, 16 bits each from bit 0 up.
    input  logic [127:0] s_tdata,
    // operation.
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status in bits 2:0, zero above.
    output logic [7:0]   m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [4:0]   cfg_wdata
);

    logic [4:0] tiles_across_reg;
    logic [4:0] tiles_down_reg;
    logic       place_all_reg;
    logic       m_tvalid_reg;
    status_t    status_reg;
    logic       out_free;
    logic       emit;
    status_t    code;
    cmd_t       cmd;
    stat_t      stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiles_across_reg <= 5'd16;
            tiles_down_reg   <= 5'd16;
            place_all_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TILES_ACROSS: tiles_across_reg <= cfg_wdata;
                CFG_TILES_DOWN:   tiles_down_reg   <= cfg_wdata;
                CFG_PLACE_ALL:    place_all_reg    <= cfg_wdata[0];
                default:          place_all_reg    <= place_all_reg;
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            status_reg <= code;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, status_reg};

    tlcp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .place_all (place_all_reg),
        .out_free  (out_free),
        .stat      (stat),
        .cmd       (cmd),
        .emit      (emit),
        .code      (code)
    );

    tlcp_dp #(
        .GRID_COLUMNS_MAX (GRID_COLUMNS_MAX),
        .GRID_ROWS_MAX    (GRID_ROWS_MAX),
        .SLOTS_PER_TILE   (SLOTS_PER_TILE),
        .TILE_PIXELS_LOG2 (TILE_PIXELS_LOG2)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .tiles_across (tiles_across_reg),
        .tiles_down   (tiles_down_reg),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
